[rtl/gbfas_pkg.sv]
// ----------------------------------------------------------------------------
// gbfas_pkg
// Shared sizes, codes and controller/datapath bundles for the grid keypoint
// store with area search.
// ----------------------------------------------------------------------------
package gbfas_pkg;

    // Grid and store geometry
    localparam int GRID_COLS   = 64;
    localparam int GRID_ROWS   = 48;
    localparam int MAX_KEYS    = 1024;
    localparam int MAX_MATCHES = 64;

    localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
    localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int KEY_W     = $clog2(MAX_KEYS);
    localparam int CNT_W     = KEY_W + 1;
    localparam int N_W       = $clog2(MAX_MATCHES + 1);

    // Field widths
    localparam int CRD_W  = 17;
    localparam int RAD_W  = 16;
    localparam int SCL_W  = 17;
    localparam int ST_W   = 3;
    localparam int OUT_CW = 6;
    localparam int OUT_RW = 6;

    // Fixed-point arithmetic: (19b signed offset) x (18b signed scale)
    localparam int OPA_W  = CRD_W + 2;
    localparam int PROD_W = OPA_W + SCL_W + 1;
    localparam int FRAC   = 20;
    localparam int VAL_W  = PROD_W - FRAC;

    // APB register map
    localparam int REG_W   = 2;
    localparam int PADDR_W = REG_W + 2;
    localparam int PDATA_W = 32;

    localparam logic [SCL_W-1:0] SCALE_RST = SCL_W'(6554);

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_OUTSIDE  = 3'd1,
        ST_MATCH    = 3'd2,
        ST_NO_MATCH = 3'd3,
        ST_CLEARED  = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        MK_COL = 3'd0,
        MK_ROW = 3'd1,
        MK_X0  = 3'd2,
        MK_X1  = 3'd3,
        MK_Y0  = 3'd4,
        MK_Y1  = 3'd5
    } t_mkind;

    typedef enum logic [REG_W-1:0] {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Y = 2'd1,
        REG_SCALE_X  = 2'd2,
        REG_SCALE_Y  = 2'd3
    } t_reg;

    typedef enum logic [4:0] {
        S_SWEEP, S_IDLE,
        S_INS, S_I1, S_I2, S_I3, S_I4,
        S_Q0, S_Q1, S_Q2, S_Q3, S_QW, S_SPAN,
        S_CRD, S_CCHK, S_KRD, S_KCHK, S_ADV, S_FIN,
        S_RESP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic    latch_in;
        logic    cnt_clr;
        logic    sweep_start;
        logic    sweep_go;
        logic    key_wr;
        logic    mul_go;
        t_mkind  mul_kind;
        logic    cell_rd_ins;
        logic    cell_wr_ins;
        logic    q_init;
        logic    cell_rd_q;
        logic    j_head;
        logic    key_rd;
        logic    j_next;
        logic    take;
        logic    adv_row;
        logic    adv_col;
        logic    push;
        t_status code;
        logic    trunc;
        logic    last;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic full;
        logic in_grid;
        logic span_empty;
        logic cell_nonempty;
        logic key_match;
        logic at_tail;
        logic n_full;
        logic n_zero;
        logic iy_end;
        logic ix_end;
        logic out_free;
    } t_sts;

endpackage

[rtl/grid_bucket_feature_area_search.sv]
// ----------------------------------------------------------------------------
// grid_bucket_feature_area_search
// Uniform-grid keypoint store with rectangular area search.
// ----------------------------------------------------------------------------
// Input beats (i_in_valid / o_in_stall) carry an action: clear, insert or area
// query. One beat is taken at a time; o_in_stall stays high until the last
// result beat of the current action has been loaded into the output register.
// Result beats leave on o_out_valid / i_out_stall from a single output
// register; o_last marks the final beat of an action.
// Insert: two multiplies on one shared multiplier, one cell table read and
// one write, then the result beat.
// Query: span setup (four multiplies), then one cell table read per cell
// visited and one key store read per list entry examined; a closing step
// ends the action. Up to 64 matches are returned.
// Clear: a sweep over all 3072 cell table entries, one per cycle, then one result beat.
// After reset the same sweep runs with o_in_stall high;
// configuration writes are taken at any time.
// A stalled output holds its beat; the sequencer waits for the register to
// free before it loads the next one.
// ----------------------------------------------------------------------------
module grid_bucket_feature_area_search
    import gbfas_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // item input
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_action,
    input  logic signed [CRD_W-1:0]  i_point_x,
    input  logic signed [CRD_W-1:0]  i_point_y,
    input  logic [RAD_W-1:0]         i_radius,
    // result output
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [ST_W-1:0]          o_status,
    output logic [KEY_W-1:0]         o_key_index,
    output logic [OUT_CW-1:0]        o_cell_col,
    output logic [OUT_RW-1:0]        o_cell_row,
    output logic                     o_truncated,
    output logic                     o_last,
    // APB configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign o_in_stall = !w_in_ready;
    assign pready     = 1'b1;

    gbfas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    gbfas_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_radius    (i_radius),
        .i_cfg_we    (psel && penable && pwrite),
        .i_cfg_idx   (paddr[PADDR_W-1:2]),
        .i_cfg_wdata (pwdata),
        .o_cfg_rdata (prdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_key_index (o_key_index),
        .o_cell_col  (o_cell_col),
        .o_cell_row  (o_cell_row),
        .o_truncated (o_truncated),
        .o_last      (o_last)
    );

endmodule

[rtl/gbfas_ctrl.sv]
// ----------------------------------------------------------------------------
// gbfas_ctrl
// Sequencer for clear, insert and area query; drives the datapath by command.
// ----------------------------------------------------------------------------
module gbfas_ctrl
    import gbfas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    t_state  r_state, n_state;
    t_status r_code, n_code;
    logic    r_after, n_after;
    logic    r_cut, n_cut;
    logic    w_proceed;

    // A match either moves on, or waits for the output register
    assign w_proceed = !i_sts.key_match ||
                       (!i_sts.n_full && (i_sts.n_zero || i_sts.out_free));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_code  <= ST_CLEARED;
            r_after <= 1'b0;
            r_cut   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_after <= n_after;
            r_cut   <= n_cut;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_after = r_after;
        n_cut   = r_cut;
        unique case (r_state)
            S_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = r_after ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_action'(i_action))
                        ACT_CLEAR: begin
                            n_state = S_SWEEP;
                            n_after = 1'b1;
                            n_code  = ST_CLEARED;
                        end
                        ACT_INSERT: n_state = S_INS;
                        ACT_QUERY:  n_state = S_Q0;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (i_sts.full) begin
                    n_state = S_RESP;
                    n_code  = ST_FULL;
                end else begin
                    n_state = S_I1;
                end
            end
            S_I1: n_state = S_I2;
            S_I2: n_state = S_I3;
            S_I3: begin
                if (i_sts.in_grid) begin
                    n_state = S_I4;
                end else begin
                    n_state = S_RESP;
                    n_code  = ST_OUTSIDE;
                end
            end
            S_I4: begin
                n_state = S_RESP;
                n_code  = ST_INSERTED;
            end
            S_Q0: n_state = S_Q1;
            S_Q1: n_state = S_Q2;
            S_Q2: n_state = S_Q3;
            S_Q3: n_state = S_QW;
            S_QW: n_state = S_SPAN;
            S_SPAN: begin
                n_cut = 1'b0;
                if (i_sts.span_empty) begin
                    n_state = S_RESP;
                    n_code  = ST_NO_MATCH;
                end else begin
                    n_state = S_CRD;
                end
            end
            S_CRD: n_state = S_CCHK;
            S_CCHK: n_state = i_sts.cell_nonempty ? S_KRD : S_ADV;
            S_KRD: n_state = S_KCHK;
            S_KCHK: begin
                if (i_sts.key_match && i_sts.n_full) begin
                    n_state = S_FIN;
                    n_cut   = 1'b1;
                end else if (w_proceed) begin
                    n_state = i_sts.at_tail ? S_ADV : S_KRD;
                end
            end
            S_ADV: begin
                if (i_sts.iy_end && i_sts.ix_end) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CRD;
                end
            end
            S_FIN: begin
                if (i_sts.n_zero) begin
                    n_state = S_RESP;
                    n_code  = ST_NO_MATCH;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    n_after = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.code = r_code;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_SWEEP: o_cmd.sweep_go = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    if (t_action'(i_action) == ACT_CLEAR) begin
                        o_cmd.sweep_start = 1'b1;
                        o_cmd.cnt_clr     = 1'b1;
                    end
                end
            end
            S_INS: begin
                if (!i_sts.full) begin
                    o_cmd.key_wr   = 1'b1;
                    o_cmd.mul_go   = 1'b1;
                    o_cmd.mul_kind = MK_COL;
                end
            end
            S_I1: begin
                o_cmd.mul_go   = 1'b1;
                o_cmd.mul_kind = MK_ROW;
            end
            S_I2: o_cmd.mul_kind = MK_COL;
            S_I3: o_cmd.cell_rd_ins = i_sts.in_grid;
            S_I4: o_cmd.cell_wr_ins = 1'b1;
            S_Q0: begin
                o_cmd.mul_go   = 1'b1;
                o_cmd.mul_kind = MK_X0;
            end
            S_Q1: begin
                o_cmd.mul_go   = 1'b1;
                o_cmd.mul_kind = MK_X1;
            end
            S_Q2: begin
                o_cmd.mul_go   = 1'b1;
                o_cmd.mul_kind = MK_Y0;
            end
            S_Q3: begin
                o_cmd.mul_go   = 1'b1;
                o_cmd.mul_kind = MK_Y1;
            end
            S_QW: o_cmd.mul_kind = MK_COL;
            S_SPAN: o_cmd.q_init = !i_sts.span_empty;
            S_CRD: o_cmd.cell_rd_q = 1'b1;
            S_CCHK: o_cmd.j_head = i_sts.cell_nonempty;
            S_KRD: o_cmd.key_rd = 1'b1;
            S_KCHK: begin
                if (!(i_sts.key_match && i_sts.n_full) && w_proceed) begin
                    o_cmd.j_next = !i_sts.at_tail;
                    if (i_sts.key_match) begin
                        o_cmd.take = 1'b1;
                        o_cmd.push = !i_sts.n_zero;
                        o_cmd.code = ST_MATCH;
                    end
                end
            end
            S_ADV: begin
                o_cmd.adv_row = !i_sts.iy_end;
                o_cmd.adv_col = i_sts.iy_end && !i_sts.ix_end;
            end
            S_FIN: begin
                o_cmd.code  = ST_MATCH;
                o_cmd.trunc = r_cut;
                o_cmd.last  = 1'b1;
                o_cmd.push  = !i_sts.n_zero && i_sts.out_free;
            end
            S_RESP: begin
                o_cmd.last = 1'b1;
                o_cmd.push = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/gbfas_dp.sv]
// ----------------------------------------------------------------------------
// gbfas_dp
// Datapath: registers, scale multiplier, key and cell stores, walk counters
// and the result register.
// ----------------------------------------------------------------------------
module gbfas_dp
    import gbfas_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    // input beat
    input  logic signed [CRD_W-1:0]  i_point_x,
    input  logic signed [CRD_W-1:0]  i_point_y,
    input  logic [RAD_W-1:0]         i_radius,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [REG_W-1:0]         i_cfg_idx,
    input  logic [PDATA_W-1:0]       i_cfg_wdata,
    output logic [PDATA_W-1:0]       o_cfg_rdata,
    // result beat
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [ST_W-1:0]          o_status,
    output logic [KEY_W-1:0]         o_key_index,
    output logic [OUT_CW-1:0]        o_cell_col,
    output logic [OUT_RW-1:0]        o_cell_row,
    output logic                     o_truncated,
    output logic                     o_last
);

    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC - 1);
    localparam logic [PROD_W-1:0] ONEM = (PROD_W'(1) << FRAC) - PROD_W'(1);
    localparam int CELL_D = 2 * KEY_W + 1;

    // Configuration registers
    logic [CRD_W-1:0] r_ox, r_oy;
    logic [SCL_W-1:0] r_sx, r_sy;

    // Latched input beat
    logic [CRD_W-1:0] r_px, r_py;
    logic [RAD_W-1:0] r_r;

    // Multiplier pipe
    logic signed [OPA_W-1:0]  w_a;
    logic signed [SCL_W:0]    w_b;
    logic signed [PROD_W-1:0] w_prod, r_prod;
    logic                     r_pv;
    t_mkind                   r_pk;
    logic [CRD_W:0]           w_bx, w_by;
    logic [PROD_W-1:0]        w_adj, w_sum, w_sh;
    logic [VAL_W-1:0]         w_val;
    logic [VAL_W-1:0]         r_col, r_row, r_x0, r_x1, r_y0, r_y1;

    // Store state
    logic [CNT_W-1:0]         r_cnt;
    logic [KEY_W-1:0]         r_idx;
    logic [2*CRD_W-1:0]       m_key [MAX_KEYS];
    logic [KEY_W-1:0]         m_link [MAX_KEYS];
    logic [CELL_D-1:0]        m_cell [NUM_CELLS];
    logic [2*CRD_W-1:0]       r_key_rd;
    logic [KEY_W-1:0]         r_link_rd;
    logic [CELL_D-1:0]        r_cell_rd;
    logic [CELL_W-1:0]        r_sw;

    // Walk state
    logic [COL_W-1:0]         r_ix, w_x0c, w_x1c;
    logic [ROW_W-1:0]         r_iy, w_y0c, w_y1c;
    logic [KEY_W-1:0]         r_j, r_tail, r_pend;
    logic [N_W-1:0]           r_n;

    logic [CELL_W-1:0]        w_ins_addr, w_q_addr, w_caddr;
    logic                     w_cwe, w_cre;
    logic [CELL_D-1:0]        w_cwd;
    logic                     w_ne;
    logic [KEY_W-1:0]         w_head, w_tl;
    logic [CRD_W:0]           w_dx, w_dy, w_adx, w_ady;
    logic                     w_out_free;

    // Configuration write and read back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0;
            r_oy <= '0;
            r_sx <= SCALE_RST;
            r_sy <= SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_ORIGIN_X: r_ox <= i_cfg_wdata[CRD_W-1:0];
                REG_ORIGIN_Y: r_oy <= i_cfg_wdata[CRD_W-1:0];
                REG_SCALE_X:  r_sx <= i_cfg_wdata[SCL_W-1:0];
                REG_SCALE_Y:  r_sy <= i_cfg_wdata[SCL_W-1:0];
                default:      r_ox <= r_ox;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(i_cfg_idx))
            REG_ORIGIN_X: o_cfg_rdata = PDATA_W'(r_ox);
            REG_ORIGIN_Y: o_cfg_rdata = PDATA_W'(r_oy);
            REG_SCALE_X:  o_cfg_rdata = PDATA_W'(r_sx);
            REG_SCALE_Y:  o_cfg_rdata = PDATA_W'(r_sy);
            default:      o_cfg_rdata = '0;
        endcase
    end

    // Hold the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_r  <= i_radius;
        end
    end

    // Multiplier operands: offset from origin, widened by the radius for spans
    assign w_bx = {r_px[CRD_W-1], r_px} - {r_ox[CRD_W-1], r_ox};
    assign w_by = {r_py[CRD_W-1], r_py} - {r_oy[CRD_W-1], r_oy};

    always_comb begin
        case (i_cmd.mul_kind)
            MK_COL: w_a = {w_bx[CRD_W], w_bx};
            MK_ROW: w_a = {w_by[CRD_W], w_by};
            MK_X0:  w_a = {w_bx[CRD_W], w_bx} - {2'b00, 1'b0, r_r};
            MK_X1:  w_a = {w_bx[CRD_W], w_bx} + {2'b00, 1'b0, r_r};
            MK_Y0:  w_a = {w_by[CRD_W], w_by} - {2'b00, 1'b0, r_r};
            MK_Y1:  w_a = {w_by[CRD_W], w_by} + {2'b00, 1'b0, r_r};
            default: w_a = '0;
        endcase
        case (i_cmd.mul_kind)
            MK_ROW, MK_Y0, MK_Y1: w_b = {1'b0, r_sy};
            default:              w_b = {1'b0, r_sx};
        endcase
    end

    assign w_prod = w_a * w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_prod <= w_prod;
            r_pk   <= i_cmd.mul_kind;
        end
    end

    // Round half away from zero, floor or ceil of the Q.20 product
    always_comb begin
        case (r_pk)
            MK_COL, MK_ROW: w_adj = r_prod[PROD_W-1] ? (HALF - PROD_W'(1)) : HALF;
            MK_X1, MK_Y1:   w_adj = ONEM;
            default:        w_adj = '0;
        endcase
        w_sum = r_prod + w_adj;
        w_sh  = $unsigned($signed(w_sum) >>> FRAC);
        w_val = w_sh[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            case (r_pk)
                MK_COL:  r_col <= w_val;
                MK_ROW:  r_row <= w_val;
                MK_X0:   r_x0  <= w_val;
                MK_X1:   r_x1  <= w_val;
                MK_Y0:   r_y0  <= w_val;
                MK_Y1:   r_y1  <= w_val;
                default: r_col <= r_col;
            endcase
        end
    end

    // Clamp the query span to the grid
    assign w_x0c = r_x0[VAL_W-1] ? '0 : r_x0[COL_W-1:0];
    assign w_y0c = r_y0[VAL_W-1] ? '0 : r_y0[ROW_W-1:0];
    assign w_x1c = (!r_x1[VAL_W-1] && (r_x1 > VAL_W'(GRID_COLS - 1))) ?
                   COL_W'(GRID_COLS - 1) : r_x1[COL_W-1:0];
    assign w_y1c = (!r_y1[VAL_W-1] && (r_y1 > VAL_W'(GRID_ROWS - 1))) ?
                   ROW_W'(GRID_ROWS - 1) : r_y1[ROW_W-1:0];

    // Key count and index of the new key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.key_wr) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr) begin
            r_idx <= r_cnt[KEY_W-1:0];
        end
    end

    // Key coordinate store
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr) begin
            m_key[r_cnt[KEY_W-1:0]] <= {r_px, r_py};
        end
        if (i_cmd.key_rd) begin
            r_key_rd <= m_key[r_j];
        end
    end

    // Per-cell list links
    assign {w_ne, w_head, w_tl} = r_cell_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_wr_ins && w_ne) begin
            m_link[w_tl] <= r_idx;
        end
        if (i_cmd.key_rd) begin
            r_link_rd <= m_link[r_j];
        end
    end

    // Cell table: {nonempty, head, tail}
    assign w_ins_addr = CELL_W'(r_col[COL_W-1:0]) * CELL_W'(GRID_ROWS) +
                        CELL_W'(r_row[ROW_W-1:0]);
    assign w_q_addr   = CELL_W'(r_ix) * CELL_W'(GRID_ROWS) + CELL_W'(r_iy);

    always_comb begin
        if (i_cmd.sweep_go) begin
            w_caddr = r_sw;
        end else if (i_cmd.cell_rd_ins || i_cmd.cell_wr_ins) begin
            w_caddr = w_ins_addr;
        end else begin
            w_caddr = w_q_addr;
        end
        w_cwe = i_cmd.sweep_go || i_cmd.cell_wr_ins;
        w_cre = i_cmd.cell_rd_ins || i_cmd.cell_rd_q;
        if (i_cmd.sweep_go) begin
            w_cwd = '0;
        end else begin
            w_cwd = {1'b1, (w_ne ? w_head : r_idx), r_idx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cwe) begin
            m_cell[w_caddr] <= w_cwd;
        end
        if (w_cre) begin
            r_cell_rd <= m_cell[w_caddr];
        end
    end

    // Clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.sweep_start) begin
            r_sw <= '0;
        end else if (i_cmd.sweep_go) begin
            r_sw <= r_sw + CELL_W'(1);
        end
    end

    // Walk over cells and list entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_init) begin
            r_ix <= w_x0c;
            r_iy <= w_y0c;
            r_n  <= '0;
        end else begin
            if (i_cmd.adv_row) begin
                r_iy <= r_iy + ROW_W'(1);
            end
            if (i_cmd.adv_col) begin
                r_ix <= r_ix + COL_W'(1);
                r_iy <= w_y0c;
            end
            if (i_cmd.take) begin
                r_n    <= r_n + N_W'(1);
                r_pend <= r_j;
            end
        end
        if (i_cmd.j_head) begin
            r_j    <= w_head;
            r_tail <= w_tl;
        end else if (i_cmd.j_next) begin
            r_j <= r_link_rd;
        end
    end

    // Distance test against the query centre
    always_comb begin
        w_dx  = {r_key_rd[2*CRD_W-1], r_key_rd[2*CRD_W-1:CRD_W]} -
                {r_px[CRD_W-1], r_px};
        w_dy  = {r_key_rd[CRD_W-1], r_key_rd[CRD_W-1:0]} - {r_py[CRD_W-1], r_py};
        w_adx = w_dx[CRD_W] ? (~w_dx + (CRD_W+1)'(1)) : w_dx;
        w_ady = w_dy[CRD_W] ? (~w_dy + (CRD_W+1)'(1)) : w_dy;
    end

    // Result register
    assign w_out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_status    <= i_cmd.code;
            o_truncated <= i_cmd.trunc;
            o_last      <= i_cmd.last;
            case (i_cmd.code)
                ST_INSERTED: begin
                    o_key_index <= r_idx;
                    o_cell_col  <= OUT_CW'(r_col[COL_W-1:0]);
                    o_cell_row  <= OUT_RW'(r_row[ROW_W-1:0]);
                end
                ST_OUTSIDE: begin
                    o_key_index <= r_idx;
                    o_cell_col  <= '0;
                    o_cell_row  <= '0;
                end
                ST_MATCH: begin
                    o_key_index <= r_pend;
                    o_cell_col  <= '0;
                    o_cell_row  <= '0;
                end
                default: begin
                    o_key_index <= '0;
                    o_cell_col  <= '0;
                    o_cell_row  <= '0;
                end
            endcase
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.sweep_last    = (r_sw == CELL_W'(NUM_CELLS - 1));
        o_sts.full          = (r_cnt == CNT_W'(MAX_KEYS));
        o_sts.in_grid       = !r_col[VAL_W-1] && (r_col < VAL_W'(GRID_COLS)) &&
                              !r_row[VAL_W-1] && (r_row < VAL_W'(GRID_ROWS));
        o_sts.span_empty    = (!r_x0[VAL_W-1] && (r_x0 >= VAL_W'(GRID_COLS))) ||
                              r_x1[VAL_W-1] ||
                              (!r_y0[VAL_W-1] && (r_y0 >= VAL_W'(GRID_ROWS))) ||
                              r_y1[VAL_W-1];
        o_sts.cell_nonempty = w_ne;
        o_sts.key_match     = (w_adx < (CRD_W+1)'(r_r)) && (w_ady < (CRD_W+1)'(r_r));
        o_sts.at_tail       = (r_j == r_tail);
        o_sts.n_full        = (r_n == N_W'(MAX_MATCHES));
        o_sts.n_zero        = (r_n == '0);
        o_sts.iy_end        = (r_iy == w_y1c);
        o_sts.ix_end        = (r_ix == w_x1c);
        o_sts.out_free      = w_out_free;
    end

endmodule
